// ===== rtl/ffst_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the first-free slot table
// no dependencies

package ffst_pkg;

    localparam int DEF_SLOTS       = 16384;
    localparam int DEF_HANDLE_BITS = 32;

    localparam int CMD_W         = 2;
    localparam int STATUS_W      = 2;
    localparam int SLOT_FIELD_W  = 14;
    localparam int COUNT_FIELD_W = 15;

    // occupancy is kept as rows of ROW_BITS slots, summarized per row and per chunk of rows
    localparam int ROW_BITS  = 64;
    localparam int ROW_SEL_W = 6;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic                 found;
        logic [ROW_SEL_W-1:0] idx;
    } find_res_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [SLOT_FIELD_W-1:0]  slot;
        logic [COUNT_FIELD_W-1:0] count;
        logic [COUNT_FIELD_W-1:0] span;
    } rsp_t;

endpackage

// ===== rtl/ffst_cmd_if.sv =====
`timescale 1ns / 1ps
// command channel of the first-free slot table
// depends on ffst_pkg

interface ffst_cmd_if #(
    parameter int HANDLE_BITS = ffst_pkg::DEF_HANDLE_BITS
);
    logic                              valid;
    logic                              ready;
    logic [ffst_pkg::CMD_W-1:0]        command;
    logic [HANDLE_BITS-1:0]            handle_in;
    logic [ffst_pkg::SLOT_FIELD_W-1:0] slot_in;

    modport source (output valid, command, handle_in, slot_in, input ready);
    modport sink (input valid, command, handle_in, slot_in, output ready);
endinterface

// ===== rtl/ffst_rsp_if.sv =====
`timescale 1ns / 1ps
// result channel of the first-free slot table
// depends on ffst_pkg

interface ffst_rsp_if #(
    parameter int HANDLE_BITS = ffst_pkg::DEF_HANDLE_BITS
);
    logic                               valid;
    logic                               ready;
    logic [ffst_pkg::STATUS_W-1:0]      status;
    logic [ffst_pkg::SLOT_FIELD_W-1:0]  slot_out;
    logic [HANDLE_BITS-1:0]             handle_out;
    logic [ffst_pkg::COUNT_FIELD_W-1:0] occupied_count;
    logic [ffst_pkg::COUNT_FIELD_W-1:0] used_span;

    modport source (output valid, status, slot_out, handle_out, occupied_count, used_span,
                    input ready);
    modport sink (input valid, status, slot_out, handle_out, occupied_count, used_span,
                  output ready);
endinterface

// ===== rtl/ffst_find.sv =====
`timescale 1ns / 1ps
// shared 64-bit find-first / find-last set bit unit
// depends on ffst_pkg

module ffst_find (
    input  logic [ffst_pkg::ROW_BITS-1:0] vec,
    input  logic                          last,
    output ffst_pkg::find_res_t           res
);
    import ffst_pkg::*;

    logic [ROW_BITS-1:0]  rev;
    logic [ROW_BITS-1:0]  src;
    logic [ROW_BITS-1:0]  low;
    logic [ROW_SEL_W-1:0] pos;

    always_comb
    begin
        for (int i = 0; i < ROW_BITS; i++)
        begin
            rev[i] = vec[ROW_BITS-1-i];
        end
        src = last ? rev : vec;
        // isolate lowest set bit
        low = src & (~src + ROW_BITS'(1));
        pos = '0;
        for (int i = 0; i < ROW_BITS; i++)
        begin
            if (low[i])
            begin
                pos = pos | ROW_SEL_W'(i);
            end
        end
        res.found = |src;
        res.idx   = last ? ~pos : pos;
    end
endmodule

// ===== rtl/ffst_core.sv =====
`timescale 1ns / 1ps
// sequencer, occupancy summaries and memories of the first-free slot table
// depends on ffst_pkg and ffst_find

module ffst_core #(
    parameter int SLOTS       = ffst_pkg::DEF_SLOTS,
    parameter int HANDLE_BITS = ffst_pkg::DEF_HANDLE_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [ffst_pkg::CMD_W-1:0]        command,
    input  logic [HANDLE_BITS-1:0]            handle_in,
    input  logic [ffst_pkg::SLOT_FIELD_W-1:0] slot_in,
    input  logic                              out_free,
    output logic                              idle,
    output logic                              done,
    output ffst_pkg::rsp_t                    rsp,
    output logic [HANDLE_BITS-1:0]            handle_out
);
    import ffst_pkg::*;

    localparam int ROWS        = (SLOTS + ROW_BITS - 1) / ROW_BITS;
    localparam int CHUNKS      = (ROWS + ROW_BITS - 1) / ROW_BITS;
    localparam int CHUNK_W     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int CHUNK_PAD   = 1 << CHUNK_W;
    localparam int ROW_W       = CHUNK_W + ROW_SEL_W;
    localparam int SUM_BITS    = CHUNK_PAD * ROW_BITS;
    localparam int ROW_ADDR_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SLOT_W      = ROW_W + ROW_SEL_W;
    localparam int SLOT_ADDR_W = $clog2(SLOTS);
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int LAST_ROW    = ROWS - 1;
    localparam int LAST_BITS   = SLOTS - LAST_ROW * ROW_BITS;

    localparam logic [ROW_BITS-1:0]  LAST_MASK  = ~({ROW_BITS{1'b1}} << LAST_BITS);
    localparam logic [SUM_BITS-1:0]  ROW_INIT   = ~({SUM_BITS{1'b1}} << ROWS);
    localparam logic [CHUNK_PAD-1:0] CHUNK_INIT = ~({CHUNK_PAD{1'b1}} << CHUNKS);

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_ADD_ROW    = 4'd1;
    localparam logic [3:0] S_ADD_BIT    = 4'd2;
    localparam logic [3:0] S_ADD_SUM    = 4'd3;
    localparam logic [3:0] S_CHECK      = 4'd4;
    localparam logic [3:0] S_REM_SUM    = 4'd5;
    localparam logic [3:0] S_SCAN_CHUNK = 4'd6;
    localparam logic [3:0] S_SCAN_ROW   = 4'd7;
    localparam logic [3:0] S_SCAN_BIT   = 4'd8;
    localparam logic [3:0] S_DONE       = 4'd9;

    logic [3:0]              state_reg, state_next;
    logic [CMD_W-1:0]        cmd_reg, cmd_next;
    logic [HANDLE_BITS-1:0]  handle_reg, handle_next;
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic [CHUNK_W-1:0]      chunk_reg, chunk_next;
    logic [ROW_W-1:0]        row_reg, row_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        span_reg, span_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic [SLOT_FIELD_W-1:0] res_slot_reg, res_slot_next;
    logic [HANDLE_BITS-1:0]  res_handle_reg, res_handle_next;
    logic [SUM_BITS-1:0]     row_free_reg, row_free_next;
    logic [SUM_BITS-1:0]     row_used_reg, row_used_next;
    logic [CHUNK_PAD-1:0]    chunk_free_reg, chunk_free_next;
    logic [CHUNK_PAD-1:0]    chunk_used_reg, chunk_used_next;

    logic [ROW_BITS-1:0]     occ_mem [ROWS];
    logic [HANDLE_BITS-1:0]  hnd_mem [SLOTS];
    logic [ROW_BITS-1:0]     occ_rd_reg;
    logic [HANDLE_BITS-1:0]  hnd_rd_reg;

    logic                    occ_rd_en;
    logic [ROW_W-1:0]        occ_rd_row;
    logic                    occ_wr_en;
    logic [ROW_BITS-1:0]     occ_wr_data;
    logic                    hnd_rd_en;
    logic                    hnd_wr_en;

    logic [ROW_BITS-1:0]     find_vec;
    logic                    find_last;
    find_res_t               find_res;

    logic [SLOT_W-1:0]       in_slot;
    logic                    in_range;
    logic [ROW_BITS-1:0]     occ_word;
    logic [ROW_BITS-1:0]     row_mask;
    logic [ROW_BITS-1:0]     free_bits;
    logic [ROW_SEL_W-1:0]    bit_idx;
    logic [ROW_BITS-1:0]     onehot;
    logic [SLOT_W-1:0]       new_slot;
    logic [ROW_W-1:0]        chunk_base;

    ffst_find u_find (
        .vec  (find_vec),
        .last (find_last),
        .res  (find_res)
    );

    assign in_slot    = SLOT_W'(slot_in);
    assign in_range   = 32'(slot_in) < 32'(SLOTS);
    // rows with no used bit read as empty, so the memory needs no clearing
    assign occ_word   = row_used_reg[row_reg] ? occ_rd_reg : '0;
    assign row_mask   = (32'(row_reg) == 32'(LAST_ROW)) ? LAST_MASK : '1;
    assign free_bits  = ~occ_word & row_mask;
    assign bit_idx    = (state_reg == S_ADD_BIT) ? find_res.idx : slot_reg[ROW_SEL_W-1:0];
    assign onehot     = ROW_BITS'(1) << bit_idx;
    assign new_slot   = {row_reg, find_res.idx};
    assign chunk_base = {chunk_reg, {ROW_SEL_W{1'b0}}};

    always_comb
    begin
        case (state_reg)
            S_IDLE:
            begin
                find_vec  = ROW_BITS'(chunk_free_reg);
                find_last = 1'b0;
            end
            S_ADD_ROW:
            begin
                find_vec  = row_free_reg[chunk_base +: ROW_BITS];
                find_last = 1'b0;
            end
            S_ADD_BIT:
            begin
                find_vec  = free_bits;
                find_last = 1'b0;
            end
            S_SCAN_CHUNK:
            begin
                find_vec  = ROW_BITS'(chunk_used_reg);
                find_last = 1'b1;
            end
            S_SCAN_ROW:
            begin
                find_vec  = row_used_reg[chunk_base +: ROW_BITS];
                find_last = 1'b1;
            end
            S_SCAN_BIT:
            begin
                find_vec  = occ_word;
                find_last = 1'b1;
            end
            default:
            begin
                find_vec  = '0;
                find_last = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        handle_next     = handle_reg;
        slot_next       = slot_reg;
        chunk_next      = chunk_reg;
        row_next        = row_reg;
        count_next      = count_reg;
        span_next       = span_reg;
        status_next     = status_reg;
        res_slot_next   = res_slot_reg;
        res_handle_next = res_handle_reg;
        row_free_next   = row_free_reg;
        row_used_next   = row_used_reg;
        chunk_free_next = chunk_free_reg;
        chunk_used_next = chunk_used_reg;
        occ_rd_en       = 1'b0;
        occ_rd_row      = row_reg;
        occ_wr_en       = 1'b0;
        occ_wr_data     = occ_word | onehot;
        hnd_rd_en       = 1'b0;
        hnd_wr_en       = 1'b0;
        done            = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next        = command;
                    handle_next     = handle_in;
                    slot_next       = in_slot;
                    res_slot_next   = slot_in;
                    res_handle_next = '0;
                    if (command == CMD_ADD)
                    begin
                        if (find_res.found)
                        begin
                            chunk_next = find_res.idx[CHUNK_W-1:0];
                            state_next = S_ADD_ROW;
                        end
                        else
                        begin
                            status_next   = STATUS_FULL;
                            res_slot_next = '0;
                            state_next    = S_DONE;
                        end
                    end
                    else if (!in_range)
                    begin
                        status_next = STATUS_EMPTY;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        row_next   = in_slot[SLOT_W-1:ROW_SEL_W];
                        chunk_next = in_slot[SLOT_W-1:SLOT_W-CHUNK_W];
                        occ_rd_en  = 1'b1;
                        occ_rd_row = in_slot[SLOT_W-1:ROW_SEL_W];
                        hnd_rd_en  = 1'b1;
                        state_next = S_CHECK;
                    end
                end
            end
            S_ADD_ROW:
            begin
                row_next   = {chunk_reg, find_res.idx};
                occ_rd_en  = 1'b1;
                occ_rd_row = {chunk_reg, find_res.idx};
                state_next = S_ADD_BIT;
            end
            S_ADD_BIT:
            begin
                slot_next                = new_slot;
                res_slot_next            = SLOT_FIELD_W'(new_slot);
                occ_wr_en                = 1'b1;
                occ_wr_data              = occ_word | onehot;
                hnd_wr_en                = 1'b1;
                row_used_next[row_reg]   = 1'b1;
                row_free_next[row_reg]   = |(free_bits & ~onehot);
                chunk_used_next[chunk_reg] = 1'b1;
                count_next               = CNT_W'(count_reg + CNT_W'(1));
                if (32'(span_reg) < 32'(new_slot) + 32'd1)
                begin
                    span_next = CNT_W'(32'(new_slot) + 32'd1);
                end
                status_next = STATUS_OK;
                state_next  = S_ADD_SUM;
            end
            S_ADD_SUM:
            begin
                chunk_free_next[chunk_reg] = |row_free_reg[chunk_base +: ROW_BITS];
                state_next                 = S_DONE;
            end
            S_CHECK:
            begin
                if (!occ_word[slot_reg[ROW_SEL_W-1:0]])
                begin
                    status_next = STATUS_EMPTY;
                    state_next  = S_DONE;
                end
                else if (cmd_reg == CMD_REMOVE)
                begin
                    occ_wr_en                  = 1'b1;
                    occ_wr_data                = occ_word & ~onehot;
                    row_free_next[row_reg]     = 1'b1;
                    chunk_free_next[chunk_reg] = 1'b1;
                    row_used_next[row_reg]     = |(occ_word & ~onehot);
                    if (count_reg != '0)
                    begin
                        count_next = CNT_W'(count_reg - CNT_W'(1));
                    end
                    status_next = STATUS_OK;
                    state_next  = S_REM_SUM;
                end
                else
                begin
                    status_next     = STATUS_OK;
                    res_handle_next = hnd_rd_reg;
                    state_next      = S_DONE;
                end
            end
            S_REM_SUM:
            begin
                chunk_used_next[chunk_reg] = |row_used_reg[chunk_base +: ROW_BITS];
                if (32'(span_reg) == 32'(slot_reg) + 32'd1)
                begin
                    state_next = S_SCAN_CHUNK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SCAN_CHUNK:
            begin
                if (find_res.found)
                begin
                    chunk_next = find_res.idx[CHUNK_W-1:0];
                    state_next = S_SCAN_ROW;
                end
                else
                begin
                    span_next  = '0;
                    state_next = S_DONE;
                end
            end
            S_SCAN_ROW:
            begin
                row_next   = {chunk_reg, find_res.idx};
                occ_rd_en  = 1'b1;
                occ_rd_row = {chunk_reg, find_res.idx};
                state_next = S_SCAN_BIT;
            end
            S_SCAN_BIT:
            begin
                span_next  = CNT_W'(32'(new_slot) + 32'd1);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            span_reg       <= '0;
            row_free_reg   <= ROW_INIT;
            row_used_reg   <= '0;
            chunk_free_reg <= CHUNK_INIT;
            chunk_used_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            span_reg       <= span_next;
            row_free_reg   <= row_free_next;
            row_used_reg   <= row_used_next;
            chunk_free_reg <= chunk_free_next;
            chunk_used_reg <= chunk_used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        handle_reg     <= handle_next;
        slot_reg       <= slot_next;
        chunk_reg      <= chunk_next;
        row_reg        <= row_next;
        status_reg     <= status_next;
        res_slot_reg   <= res_slot_next;
        res_handle_reg <= res_handle_next;
    end

    always_ff @(posedge clk)
    begin
        if (occ_wr_en)
        begin
            occ_mem[row_reg[ROW_ADDR_W-1:0]] <= occ_wr_data;
        end
        if (occ_rd_en)
        begin
            occ_rd_reg <= occ_mem[occ_rd_row[ROW_ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (hnd_wr_en)
        begin
            hnd_mem[new_slot[SLOT_ADDR_W-1:0]] <= handle_reg;
        end
        if (hnd_rd_en)
        begin
            hnd_rd_reg <= hnd_mem[in_slot[SLOT_ADDR_W-1:0]];
        end
    end

    assign idle       = (state_reg == S_IDLE);
    assign rsp.status = status_reg;
    assign rsp.slot   = res_slot_reg;
    assign rsp.count  = COUNT_FIELD_W'(count_reg);
    assign rsp.span   = COUNT_FIELD_W'(span_reg);
    assign handle_out = res_handle_reg;

    // span and count agree once an item is finished
    a_idle_span_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ((count_reg == '0) == (span_reg == '0)))
        else $error("span and count disagree on emptiness");

    a_idle_count_span: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (32'(count_reg) <= 32'(span_reg)))
        else $error("occupied count exceeds used span");

    // summaries must point at a row that really has what was searched for
    a_add_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD_ROW || state_reg == S_ADD_BIT) |-> find_res.found)
        else $error("free summary points at a full row");

    a_scan_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN_ROW || state_reg == S_SCAN_BIT) |-> find_res.found)
        else $error("used summary points at an empty row");
endmodule

// ===== rtl/first_free_slot_table.sv =====
`timescale 1ns / 1ps
// First-fit slot table with a high-water mark. An add steps from acceptance
// through the chunk summary, the row summary and the chosen row to a waiting
// result (at once when full), a read or a remove of a slot that is not the
// highest checks that slot's row, and a remove of the highest slot also rescans
// downward. These steps use a single 64-bit find-first/find-last unit in turn
// on the chunk summary, the row summary and one row of the occupancy memory,
// whose read is registered. The next item is accepted in the cycle after a
// result is loaded into the output register, even while that result still waits
// to be taken. There is no clearing pass: the table is usable right after reset.
// depends on ffst_pkg, ffst_cmd_if, ffst_rsp_if and ffst_core

module first_free_slot_table #(
    parameter int SLOTS       = ffst_pkg::DEF_SLOTS,
    parameter int HANDLE_BITS = ffst_pkg::DEF_HANDLE_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    ffst_cmd_if.sink  cmd,
    ffst_rsp_if.source rsp
);
    import ffst_pkg::*;

    logic                   core_idle;
    logic                   core_done;
    logic                   out_free;
    rsp_t                   core_rsp;
    logic [HANDLE_BITS-1:0] core_handle;

    logic                   out_valid_reg;
    rsp_t                   rsp_reg;
    logic [HANDLE_BITS-1:0] handle_reg;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign cmd.ready = core_idle;

    ffst_core #(
        .SLOTS       (SLOTS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (cmd.valid),
        .command    (cmd.command),
        .handle_in  (cmd.handle_in),
        .slot_in    (cmd.slot_in),
        .out_free   (out_free),
        .idle       (core_idle),
        .done       (core_done),
        .rsp        (core_rsp),
        .handle_out (core_handle)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (core_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_done)
        begin
            rsp_reg    <= core_rsp;
            handle_reg <= core_handle;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = rsp_reg.status;
    assign rsp.slot_out       = rsp_reg.slot;
    assign rsp.handle_out     = handle_reg;
    assign rsp.occupied_count = rsp_reg.count;
    assign rsp.used_span      = rsp_reg.span;
endmodule
